[src/cad_pkg.sv]
// ----------------------------------------------------------------------------
// cad_pkg - shared definitions for the chunked array address unit
// Register codes, default sizes and the configuration bundle that the
// register block hands to the datapath.
// ----------------------------------------------------------------------------
package cad_pkg;

    // Fixed sizes of the interface
    localparam int DIMS_MAX        = 4;
    localparam int LEN_W           = 16;
    localparam int WORD_W          = 32;
    localparam int ACTIVE_W        = 3;
    localparam int ADDR_W          = 5;
    localparam int NUM_DIMS_DEF    = 4;
    localparam int COORD_WIDTH_DEF = 16;

    // Register indexes (paddr[4:2])
    localparam logic [2:0] REG_ACTIVE_DIMS   = 3'd0;
    localparam logic [2:0] REG_CHUNK_LEN_A   = 3'd1;
    localparam logic [2:0] REG_CHUNK_LEN_B   = 3'd2;
    localparam logic [2:0] REG_CHUNK_LEN_C   = 3'd3;
    localparam logic [2:0] REG_CHUNK_LEN_D   = 3'd4;
    localparam logic [2:0] REG_CHUNK_COUNT_A = 3'd5;
    localparam logic [2:0] REG_CHUNK_COUNT_B = 3'd6;
    localparam logic [2:0] REG_CHUNK_COUNT_C = 3'd7;

    // Reset values
    localparam logic [ACTIVE_W-1:0] ACTIVE_DIMS_RST = 3'd4;
    localparam logic [LEN_W-1:0]    CHUNK_RST       = 16'd1;

    // Configuration bundle seen by the datapath
    typedef struct packed {
        logic [DIMS_MAX-1:0]              active;     // dimension takes part
        logic [DIMS_MAX-1:0][LEN_W-1:0]   chunk_len;  // divisor per dimension
        logic [DIMS_MAX-1:0][WORD_W-1:0]  count_w;    // mixed radix weight, number
        logic [DIMS_MAX-1:0][WORD_W-1:0]  len_w;      // mixed radix weight, offset
    } cad_cfg_t;

endpackage

[src/cad_regs.sv]
// ----------------------------------------------------------------------------
// cad_regs - configuration registers
// APB register file plus the running products of chunk counts and chunk
// lengths that weight each dimension.
// ----------------------------------------------------------------------------
module cad_regs
    import cad_pkg::*;
#(
    parameter int NUM_DIMS = NUM_DIMS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0] pwdata,
    output logic [WORD_W-1:0] prdata,
    output logic              pready,
    output cad_cfg_t          cfg
);

    logic [ACTIVE_W-1:0] active_dims_reg;
    logic [LEN_W-1:0]    len_a_reg, len_b_reg, len_c_reg, len_d_reg;
    logic [LEN_W-1:0]    count_a_reg, count_b_reg, count_c_reg;
    logic [WORD_W-1:0]   count_w2_reg, count_w3_reg;
    logic [WORD_W-1:0]   len_w2_reg, len_w3_reg;
    logic [WORD_W-1:0]   count_w2_next, count_w3_next;
    logic [WORD_W-1:0]   len_w2_next, len_w3_next;
    logic                wr_en;
    logic [2:0]          reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    // Write the register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_dims_reg <= ACTIVE_DIMS_RST;
            len_a_reg       <= CHUNK_RST;
            len_b_reg       <= CHUNK_RST;
            len_c_reg       <= CHUNK_RST;
            len_d_reg       <= CHUNK_RST;
            count_a_reg     <= CHUNK_RST;
            count_b_reg     <= CHUNK_RST;
            count_c_reg     <= CHUNK_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_ACTIVE_DIMS:   active_dims_reg <= pwdata[ACTIVE_W-1:0];
                REG_CHUNK_LEN_A:   len_a_reg       <= pwdata[LEN_W-1:0];
                REG_CHUNK_LEN_B:   len_b_reg       <= pwdata[LEN_W-1:0];
                REG_CHUNK_LEN_C:   len_c_reg       <= pwdata[LEN_W-1:0];
                REG_CHUNK_LEN_D:   len_d_reg       <= pwdata[LEN_W-1:0];
                REG_CHUNK_COUNT_A: count_a_reg     <= pwdata[LEN_W-1:0];
                REG_CHUNK_COUNT_B: count_b_reg     <= pwdata[LEN_W-1:0];
                REG_CHUNK_COUNT_C: count_c_reg     <= pwdata[LEN_W-1:0];
                default:           active_dims_reg <= active_dims_reg;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (reg_idx)
            REG_ACTIVE_DIMS:   prdata = WORD_W'(active_dims_reg);
            REG_CHUNK_LEN_A:   prdata = WORD_W'(len_a_reg);
            REG_CHUNK_LEN_B:   prdata = WORD_W'(len_b_reg);
            REG_CHUNK_LEN_C:   prdata = WORD_W'(len_c_reg);
            REG_CHUNK_LEN_D:   prdata = WORD_W'(len_d_reg);
            REG_CHUNK_COUNT_A: prdata = WORD_W'(count_a_reg);
            REG_CHUNK_COUNT_B: prdata = WORD_W'(count_b_reg);
            REG_CHUNK_COUNT_C: prdata = WORD_W'(count_c_reg);
            default:           prdata = '0;
        endcase
    end

    // Build the weights, one multiply per register stage
    always_comb
    begin
        count_w2_next = WORD_W'(count_a_reg) * WORD_W'(count_b_reg);
        count_w3_next = count_w2_reg * WORD_W'(count_c_reg);
        len_w2_next   = WORD_W'(len_a_reg) * WORD_W'(len_b_reg);
        len_w3_next   = len_w2_reg * WORD_W'(len_c_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_w2_reg <= WORD_W'(1);
            count_w3_reg <= WORD_W'(1);
            len_w2_reg   <= WORD_W'(1);
            len_w3_reg   <= WORD_W'(1);
        end
        else
        begin
            count_w2_reg <= count_w2_next;
            count_w3_reg <= count_w3_next;
            len_w2_reg   <= len_w2_next;
            len_w3_reg   <= len_w3_next;
        end
    end

    // Drive the bundle; a dimension above the lane count never takes part
    always_comb
    begin
        for (int i = 0; i < DIMS_MAX; i++)
        begin
            cfg.active[i] = (ACTIVE_W'(i) < active_dims_reg) && (i < NUM_DIMS);
        end
        cfg.chunk_len[0] = len_a_reg;
        cfg.chunk_len[1] = len_b_reg;
        cfg.chunk_len[2] = len_c_reg;
        cfg.chunk_len[3] = len_d_reg;
        cfg.count_w[0]   = WORD_W'(1);
        cfg.count_w[1]   = WORD_W'(count_a_reg);
        cfg.count_w[2]   = count_w2_reg;
        cfg.count_w[3]   = count_w3_reg;
        cfg.len_w[0]     = WORD_W'(1);
        cfg.len_w[1]     = WORD_W'(len_a_reg);
        cfg.len_w[2]     = len_w2_reg;
        cfg.len_w[3]     = len_w3_reg;
    end

endmodule

[src/cad_div_cell.sv]
// ----------------------------------------------------------------------------
// cad_div_cell - one restoring division step
// Shifts the next dividend bit into the partial remainder of every lane,
// subtracts the divisor where it fits and shifts the quotient bit in.
// ----------------------------------------------------------------------------
module cad_div_cell
    import cad_pkg::*;
#(
    parameter int NUM_DIMS    = NUM_DIMS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic [NUM_DIMS-1:0][LEN_W-1:0]          divisor,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [NUM_DIMS-1:0][COORD_WIDTH-1:0]    in_rem,
    input  logic [NUM_DIMS-1:0][COORD_WIDTH-1:0]    in_quo,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [NUM_DIMS-1:0][COORD_WIDTH-1:0]    out_rem,
    output logic [NUM_DIMS-1:0][COORD_WIDTH-1:0]    out_quo
);

    localparam int CMP_W = (COORD_WIDTH > LEN_W) ? COORD_WIDTH : LEN_W;

    logic                                 valid_reg;
    logic [NUM_DIMS-1:0][COORD_WIDTH-1:0] rem_reg, quo_reg;
    logic [NUM_DIMS-1:0][COORD_WIDTH-1:0] rem_next, quo_next;
    logic [COORD_WIDTH-1:0]               shifted;
    logic [CMP_W-1:0]                     shifted_ext, div_ext;
    logic                                 fits;

    assign in_ready = !valid_reg || out_ready;

    // One step per lane
    always_comb
    begin
        for (int i = 0; i < NUM_DIMS; i++)
        begin
            shifted     = {in_rem[i][COORD_WIDTH-2:0], in_quo[i][COORD_WIDTH-1]};
            shifted_ext = CMP_W'(shifted);
            div_ext     = CMP_W'(divisor[i]);
            fits        = shifted_ext >= div_ext;
            rem_next[i] = fits ? COORD_WIDTH'(shifted_ext - div_ext) : shifted;
            quo_next[i] = {in_quo[i][COORD_WIDTH-2:0], fits};
        end
    end

    // Hold the word until the next cell takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;

endmodule

[src/cad_combine.sv]
// ----------------------------------------------------------------------------
// cad_combine - mixed radix combine
// Weights quotients and remainders by the per-dimension products, then
// sums them over two adder stages into the output register.
// ----------------------------------------------------------------------------
module cad_combine
    import cad_pkg::*;
#(
    parameter int NUM_DIMS    = NUM_DIMS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  cad_cfg_t                                cfg,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [NUM_DIMS-1:0][COORD_WIDTH-1:0]    in_quo,
    input  logic [NUM_DIMS-1:0][COORD_WIDTH-1:0]    in_rem,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [WORD_W-1:0]                       chunk_number,
    output logic [WORD_W-1:0]                       chunk_offset
);

    // Only the low word of each product is kept
    localparam int PROD_W = WORD_W;

    logic                             mul_valid_reg, pair_valid_reg, sum_valid_reg;
    logic                             mul_ready, pair_ready, sum_ready;
    logic [DIMS_MAX-1:0][WORD_W-1:0]  num_term_next, off_term_next;
    logic [DIMS_MAX-1:0][WORD_W-1:0]  num_term_reg, off_term_reg;
    logic [1:0][WORD_W-1:0]           num_pair_reg, off_pair_reg;
    logic [WORD_W-1:0]                num_sum_reg, off_sum_reg;

    // Weight each active lane, zero the rest
    genvar g;
    generate
        for (g = 0; g < DIMS_MAX; g++)
        begin : g_lane
            if (g < NUM_DIMS)
            begin : g_used
                logic [PROD_W-1:0] num_full, off_full;
                assign num_full = PROD_W'(in_quo[g]) * PROD_W'(cfg.count_w[g]);
                assign off_full = PROD_W'(in_rem[g]) * PROD_W'(cfg.len_w[g]);
                assign num_term_next[g] = cfg.active[g] ? num_full[WORD_W-1:0] : '0;
                assign off_term_next[g] = cfg.active[g] ? off_full[WORD_W-1:0] : '0;
            end
            else
            begin : g_unused
                assign num_term_next[g] = '0;
                assign off_term_next[g] = '0;
            end
        end
    endgenerate

    assign sum_ready  = !sum_valid_reg || out_ready;
    assign pair_ready = !pair_valid_reg || sum_ready;
    assign mul_ready  = !mul_valid_reg || pair_ready;
    assign in_ready   = mul_ready;

    // Advance the stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg  <= 1'b0;
            pair_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            if (mul_ready)
            begin
                mul_valid_reg <= in_valid;
            end
            if (pair_ready)
            begin
                pair_valid_reg <= mul_valid_reg;
            end
            if (sum_ready)
            begin
                sum_valid_reg <= pair_valid_reg;
            end
        end
    end

    // Products, pair sums, final sums
    always_ff @(posedge clk)
    begin
        if (in_valid && mul_ready)
        begin
            num_term_reg <= num_term_next;
            off_term_reg <= off_term_next;
        end
        if (mul_valid_reg && pair_ready)
        begin
            num_pair_reg[0] <= num_term_reg[0] + num_term_reg[1];
            num_pair_reg[1] <= num_term_reg[2] + num_term_reg[3];
            off_pair_reg[0] <= off_term_reg[0] + off_term_reg[1];
            off_pair_reg[1] <= off_term_reg[2] + off_term_reg[3];
        end
        if (pair_valid_reg && sum_ready)
        begin
            num_sum_reg <= num_pair_reg[0] + num_pair_reg[1];
            off_sum_reg <= off_pair_reg[0] + off_pair_reg[1];
        end
    end

    assign out_valid    = sum_valid_reg;
    assign chunk_number = num_sum_reg;
    assign chunk_offset = off_sum_reg;

endmodule

[src/chunked_array_address_unit.sv]
// ----------------------------------------------------------------------------
// chunked_array_address_unit - chunk number and offset of an array element
// Pipeline: one division cell per coordinate bit, one multiply stage, two adder
//   stages; every stage is a register with its own valid.
// Throughput: one word per cycle unless m_tready is low and stalls the stages.
// After a write the weights settle through count_w2/len_w2, then count_w3/len_w3.
// Reset clears all valids and loads the register defaults (four dimensions,
//   chunk lengths and counts of one).
// ----------------------------------------------------------------------------
module chunked_array_address_unit
    import cad_pkg::*;
#(
    parameter int NUM_DIMS    = NUM_DIMS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int IN_W        = ((DIMS_MAX * COORD_WIDTH + 7) / 8) * 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    // Configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [WORD_W-1:0]   pwdata,
    output logic [WORD_W-1:0]   prdata,
    output logic                pready,
    // Input words
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_W-1:0]     s_tdata,    // coord_a, coord_b, coord_c, coord_d
    // Output words
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [2*WORD_W-1:0] m_tdata     // chunk_number, chunk_offset
);

    cad_cfg_t                             cfg;
    logic [NUM_DIMS-1:0][LEN_W-1:0]       divisor;
    logic [COORD_WIDTH:0]                 link_valid, link_ready;
    logic [NUM_DIMS-1:0][COORD_WIDTH-1:0] link_rem [COORD_WIDTH+1];
    logic [NUM_DIMS-1:0][COORD_WIDTH-1:0] link_quo [COORD_WIDTH+1];
    logic [WORD_W-1:0]                    chunk_number, chunk_offset;

    cad_regs #(
        .NUM_DIMS (NUM_DIMS)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Feed the first cell: empty remainder, dividend in the quotient register
    genvar d, k;
    generate
        for (d = 0; d < NUM_DIMS; d++)
        begin : g_feed
            assign divisor[d]     = cfg.chunk_len[d];
            assign link_rem[0][d] = '0;
            assign link_quo[0][d] = s_tdata[d*COORD_WIDTH +: COORD_WIDTH];
        end
    endgenerate

    assign link_valid[0] = s_tvalid;
    assign s_tready      = link_ready[0];

    // Division chain, one quotient bit per cell
    generate
        for (k = 0; k < COORD_WIDTH; k++)
        begin : g_cell
            cad_div_cell #(
                .NUM_DIMS    (NUM_DIMS),
                .COORD_WIDTH (COORD_WIDTH)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .divisor   (divisor),
                .in_valid  (link_valid[k]),
                .in_ready  (link_ready[k]),
                .in_rem    (link_rem[k]),
                .in_quo    (link_quo[k]),
                .out_valid (link_valid[k+1]),
                .out_ready (link_ready[k+1]),
                .out_rem   (link_rem[k+1]),
                .out_quo   (link_quo[k+1])
            );
        end
    endgenerate

    cad_combine #(
        .NUM_DIMS    (NUM_DIMS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_combine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (link_valid[COORD_WIDTH]),
        .in_ready     (link_ready[COORD_WIDTH]),
        .in_quo       (link_quo[COORD_WIDTH]),
        .in_rem       (link_rem[COORD_WIDTH]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .chunk_number (chunk_number),
        .chunk_offset (chunk_offset)
    );

    assign m_tdata = {chunk_offset, chunk_number};

    // A draining output lets every stage advance, so the input is open
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input blocked while output drains");

    // The final remainder stays below a nonzero chunk length
    assert property (@(posedge clk) disable iff (!rst_n)
        link_valid[COORD_WIDTH] && (cfg.chunk_len[0] != '0) |->
            (WORD_W'(link_rem[COORD_WIDTH][0]) < WORD_W'(cfg.chunk_len[0])))
        else $error("remainder not below chunk length");

    // No active dimension gives a zero result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (cfg.active == '0) |-> (m_tdata == '0))
        else $error("nonzero result with no active dimension");

endmodule
